// ----- design/ipc_pkg.sv -----
package ipc_pkg;

    typedef enum logic [1:0] {
        CMD_SEND   = 2'd0,
        CMD_RECV   = 2'd1,
        CMD_NOTIFY = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_DEADLOCK  = 3'd2,
        ST_INT_DONE  = 3'd3,
        ST_INT_LATCH = 3'd4
    } t_status;

    localparam logic [1:0] KIND_SPECIFIC = 2'd0;
    localparam logic [1:0] KIND_ANY      = 2'd1;
    localparam logic [1:0] KIND_INT      = 2'd2;
    localparam logic [1:0] KIND_ANY_ALT  = 2'd3;

    typedef enum logic [1:0] {
        WANT_NONE = 2'd0,
        WANT_ANY  = 2'd1,
        WANT_INT  = 2'd2,
        WANT_PROC = 2'd3
    } t_want;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHAIN,
        S_SEND_DONE,
        S_APPEND,
        S_RECV_SCAN,
        S_RECV_DONE,
        S_OUT
    } t_state;

endpackage

// ----- design/ipc_rendezvous_engine.sv -----
// A receive that takes the head of its sender queue needs no walk; a receive from
// a specific source scans its sender queue, and a send walks the send chain and
// then the sender queue, one link per cycle through one shared walker.
// Throughput: one request at a time; the next is taken the cycle after the result is accepted.
// Reset clears all marks, queues and interrupt flags.
module ipc_rendezvous_engine import ipc_pkg::*; #(
    parameter int NUM_PROCS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd, caller, peer, peer_kind, buffer_ref
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // status, copy_valid, copy_from_ref,
                                        // copy_is_interrupt, copy_to_ref,
                                        // message_source, woken_valid, woken_proc
);

    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CW = $clog2(NUM_PROCS + 1);

    logic          r_snd   [NUM_PROCS];
    logic          r_rcv   [NUM_PROCS];
    logic          r_intp  [NUM_PROCS];
    logic [PW-1:0] r_tgt   [NUM_PROCS];
    t_want         r_wkind [NUM_PROCS];
    logic [PW-1:0] r_wproc [NUM_PROCS];
    logic          r_hv    [NUM_PROCS];
    logic [PW-1:0] r_head  [NUM_PROCS];
    logic          r_lv    [NUM_PROCS];
    logic [PW-1:0] r_link  [NUM_PROCS];
    logic [31:0]   r_buf   [NUM_PROCS];

    t_state        r_state, n_state;
    logic [1:0]    r_cmd;
    logic [PW-1:0] r_c, r_peer, r_p, r_prev;
    logic [1:0]    r_kind;
    logic [31:0]   r_ibuf;
    logic [CW-1:0] r_n;
    logic          r_prev_v;
    logic [87:0]   r_out;

    function automatic logic [PW-1:0] proc_index(logic [4:0] v);
        proc_index = '0;
        for (int i = 0; i < 32; i++) begin
            if (v == 5'(i)) proc_index = PW'(i % NUM_PROCS);
        end
    endfunction

    function automatic logic [87:0] pack(t_status st, logic cv, logic [31:0] fr,
            logic ii, logic [31:0] to, logic [4:0] src, logic wv, logic [4:0] wp);
        pack = {8'b0, wp, wv, src, to, ii, fr, cv, st};
    endfunction

    logic [PW-1:0] w_c, w_peer;
    assign w_c    = proc_index(s_axis_tdata[6:2]);
    assign w_peer = proc_index(s_axis_tdata[11:7]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

    logic w_any, w_busy, w_take_int, w_take_head, w_scan, w_meet;
    assign w_any       = (r_kind == KIND_ANY) || (r_kind == KIND_ANY_ALT);
    assign w_busy      = r_snd[r_c] || r_rcv[r_c];
    assign w_take_int  = r_intp[r_c] && (w_any || r_kind == KIND_INT);
    assign w_take_head = w_any && r_hv[r_c];
    assign w_scan      = (r_kind == KIND_SPECIFIC) && r_snd[r_peer] &&
                         (r_tgt[r_peer] == r_c) && r_hv[r_c];
    assign w_meet      = r_rcv[r_peer] && (r_wkind[r_peer] == WANT_ANY ||
                         (r_wkind[r_peer] == WANT_PROC && r_wproc[r_peer] == r_c));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (r_cmd == CMD_SEND && !w_busy && r_c != r_peer) begin
                    n_state = S_CHAIN;
                end else if (r_cmd == CMD_RECV && !w_busy && !w_take_int) begin
                    if (w_take_head) begin
                        n_state = S_RECV_DONE;
                    end else if (w_scan) begin
                        n_state = S_RECV_SCAN;
                    end
                end
            end
            S_CHAIN: begin
                if (r_n == CW'(NUM_PROCS) || !r_snd[r_p]) begin
                    n_state = S_SEND_DONE;
                end else if (r_tgt[r_p] == r_c) begin
                    n_state = S_OUT;
                end
            end
            S_SEND_DONE: begin
                if (w_meet || !r_hv[r_peer]) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                if (!r_lv[r_p] || r_n == CW'(NUM_PROCS)) n_state = S_OUT;
            end
            S_RECV_SCAN: begin
                if (r_p == r_peer) begin
                    n_state = S_RECV_DONE;
                end else if (!r_lv[r_p] || r_n == CW'(NUM_PROCS)) begin
                    n_state = S_OUT;
                end
            end
            S_RECV_DONE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                r_snd[i]   <= 1'b0;
                r_rcv[i]   <= 1'b0;
                r_intp[i]  <= 1'b0;
                r_tgt[i]   <= '0;
                r_wkind[i] <= WANT_NONE;
                r_wproc[i] <= '0;
                r_hv[i]    <= 1'b0;
                r_head[i]  <= '0;
                r_lv[i]    <= 1'b0;
                r_link[i]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd  <= s_axis_tdata[1:0];
                        r_c    <= w_c;
                        r_peer <= w_peer;
                        r_kind <= s_axis_tdata[13:12];
                        r_ibuf <= s_axis_tdata[45:14];
                    end
                end
                S_DECODE: begin
                    if (r_cmd == CMD_NOTIFY) begin
                        if (r_rcv[r_c] && (r_wkind[r_c] == WANT_INT ||
                                           r_wkind[r_c] == WANT_ANY)) begin
                            r_intp[r_c]  <= 1'b0;
                            r_rcv[r_c]   <= 1'b0;
                            r_wkind[r_c] <= WANT_NONE;
                            r_out <= pack(ST_INT_DONE, 1'b1, '0, 1'b1, r_buf[r_c],
                                          '0, 1'b1, 5'(r_c));
                        end else begin
                            r_intp[r_c] <= 1'b1;
                            r_out <= pack(ST_INT_LATCH, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                        end
                    end else if (r_cmd == CMD_NONE) begin
                        r_out <= pack(ST_DELIVERED, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                    end else if (w_busy) begin
                        r_out <= pack(ST_BLOCKED, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                    end else if (r_cmd == CMD_SEND) begin
                        if (r_c == r_peer) begin
                            r_out <= pack(ST_DEADLOCK, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                        end else begin
                            r_p <= r_peer;
                            r_n <= '0;
                        end
                    end else begin
                        if (w_take_int) begin
                            r_intp[r_c] <= 1'b0;
                            r_out <= pack(ST_INT_DONE, 1'b1, '0, 1'b1, r_ibuf,
                                          '0, 1'b0, '0);
                        end else if (w_take_head) begin
                            r_p      <= r_head[r_c];
                            r_prev_v <= 1'b0;
                        end else if (w_scan) begin
                            r_p      <= r_head[r_c];
                            r_prev_v <= 1'b0;
                            r_n      <= '0;
                        end else begin
                            r_rcv[r_c] <= 1'b1;
                            r_buf[r_c] <= r_ibuf;
                            r_wkind[r_c] <= w_any ? WANT_ANY :
                                (r_kind == KIND_INT ? WANT_INT : WANT_PROC);
                            r_wproc[r_c] <= r_peer;
                            r_out <= pack(ST_BLOCKED, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                        end
                    end
                end
                S_CHAIN: begin
                    if (r_n != CW'(NUM_PROCS) && r_snd[r_p]) begin
                        if (r_tgt[r_p] == r_c) begin
                            r_out <= pack(ST_DEADLOCK, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                        end else begin
                            r_p <= r_tgt[r_p];
                            r_n <= r_n + 1'b1;
                        end
                    end
                end
                S_SEND_DONE: begin
                    if (w_meet) begin
                        r_rcv[r_peer]   <= 1'b0;
                        r_wkind[r_peer] <= WANT_NONE;
                        r_out <= pack(ST_DELIVERED, 1'b1, r_ibuf, 1'b0, r_buf[r_peer],
                                      5'(r_c), 1'b1, 5'(r_peer));
                    end else begin
                        r_snd[r_c] <= 1'b1;
                        r_tgt[r_c] <= r_peer;
                        r_buf[r_c] <= r_ibuf;
                        r_lv[r_c]  <= 1'b0;
                        r_out <= pack(ST_BLOCKED, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                        if (!r_hv[r_peer]) begin
                            r_hv[r_peer]   <= 1'b1;
                            r_head[r_peer] <= r_c;
                        end else begin
                            r_p <= r_head[r_peer];
                            r_n <= '0;
                        end
                    end
                end
                S_APPEND: begin
                    if (!r_lv[r_p] || r_n == CW'(NUM_PROCS)) begin
                        r_lv[r_p]   <= 1'b1;
                        r_link[r_p] <= r_c;
                    end else begin
                        r_p <= r_link[r_p];
                        r_n <= r_n + 1'b1;
                    end
                end
                S_RECV_SCAN: begin
                    if (r_p == r_peer) begin
                    end else if (!r_lv[r_p] || r_n == CW'(NUM_PROCS)) begin
                        r_rcv[r_c]   <= 1'b1;
                        r_buf[r_c]   <= r_ibuf;
                        r_wkind[r_c] <= WANT_PROC;
                        r_wproc[r_c] <= r_peer;
                        r_out <= pack(ST_BLOCKED, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0);
                    end else begin
                        r_prev   <= r_p;
                        r_prev_v <= 1'b1;
                        r_p      <= r_link[r_p];
                        r_n      <= r_n + 1'b1;
                    end
                end
                S_RECV_DONE: begin
                    if (r_prev_v) begin
                        r_lv[r_prev]   <= r_lv[r_p];
                        r_link[r_prev] <= r_link[r_p];
                    end else begin
                        r_hv[r_c]   <= r_lv[r_p];
                        r_head[r_c] <= r_link[r_p];
                    end
                    r_lv[r_p]  <= 1'b0;
                    r_buf[r_p] <= '0;
                    r_tgt[r_p] <= '0;
                    r_snd[r_p] <= 1'b0;
                    r_out <= pack(ST_DELIVERED, 1'b1, r_buf[r_p], 1'b0, r_ibuf,
                                  5'(r_p), 1'b1, 5'(r_p));
                end
                S_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule
